@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk, off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/imm_pkg.sv @@
// ---------------------------------------------------------------------------
// imm_pkg
// widths, reset values and register indexes of the integer matrix multiplier
// ---------------------------------------------------------------------------
package imm_pkg;

    localparam int MAX_DIM_DEF = 8;

    localparam int ELEM_W    = 32;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_OUT_W = 3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

endpackage

@@ hw/rtl/integer_matrix_multiply_core.sv @@
// ---------------------------------------------------------------------------
// integer_matrix_multiply_core
// signed 32-bit matrix product A*B with one shared multiply-accumulate unit
// ---------------------------------------------------------------------------
// Elements arrive one per item, A (rows_a x inner_len) then B (inner_len x
// cols_b), both row-major, and input ready stays high while loading. The item
// that carries the last B element starts the computation: the block then
// takes no input until it has issued all rows_a*cols_b*inner_len terms, one
// multiply-accumulate per cycle through a single 32x32 multiplier fed by the
// two element memories while no product item is held waiting to be taken.
// Each product item passes the memory read, multiply and accumulate registers
// after its last term is issued, so the final one follows the return of input
// ready. Products wrap to 32 bits. Dimension registers read as 0 count as 1 and
// values above MAX_DIM count as MAX_DIM; writing any register restarts the
// load at A[0][0].
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_matrix_multiply_core
    import imm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [DIM_W-1:0]            cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [ELEM_W-1:0]    element,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [ELEM_W-1:0]    product,
    output logic [IDX_OUT_W-1:0]        out_row,
    output logic [IDX_OUT_W-1:0]        out_col,
    output logic                        last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int CW    = $clog2(MAX_DIM + 1);

    typedef enum logic {ST_LOAD, ST_CALC} state_t;

    typedef struct packed {
        logic          first;
        logic          lastk;
        logic          fin;
        logic [IW-1:0] r;
        logic [IW-1:0] c;
    } tag_t;

    function automatic logic [CW-1:0] eff_dim(input logic [DIM_W-1:0] v);
        int d;
        d = int'(v);
        if (d < 1)
        begin
            d = 1;
        end
        if (d > MAX_DIM)
        begin
            d = MAX_DIM;
        end
        return CW'(d);
    endfunction

    state_t              state_reg, state_next;
    logic [DIM_W-1:0]    rows_a_reg, rows_a_next;
    logic [DIM_W-1:0]    inner_len_reg, inner_len_next;
    logic [DIM_W-1:0]    cols_b_reg, cols_b_next;
    logic                ld_b_reg, ld_b_next;
    logic [IW-1:0]       ld_hi_reg, ld_hi_next;
    logic [IW-1:0]       ld_lo_reg, ld_lo_next;
    logic [IW-1:0]       r_reg, r_next;
    logic [IW-1:0]       c_reg, c_next;
    logic [IW-1:0]       k_reg, k_next;
    logic                v1_reg, v1_next;
    tag_t                tag1_reg, tag1_next;
    logic                v2_reg, v2_next;
    tag_t                tag2_reg, tag2_next;
    logic [ELEM_W-1:0]   prod_reg, prod_next;
    logic [ELEM_W-1:0]   acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]   product_reg, product_next;
    logic [IDX_OUT_W-1:0] out_row_reg, out_row_next;
    logic [IDX_OUT_W-1:0] out_col_reg, out_col_next;
    logic                last_reg, last_next;

    logic [CW-1:0]       nr, nk, nc;
    logic [IW-1:0]       nr_m1, nk_m1, nc_m1;
    logic                adv;
    logic                in_fire;
    logic                lo_last, hi_last;
    logic                issue;
    tag_t                issue_tag;
    logic [AW-1:0]       wr_addr, rd_a_addr, rd_b_addr;
    logic [ELEM_W-1:0]   a_rdata, b_rdata;
    logic [ELEM_W-1:0]   sum;

    assign nr    = eff_dim(rows_a_reg);
    assign nk    = eff_dim(inner_len_reg);
    assign nc    = eff_dim(cols_b_reg);
    assign nr_m1 = IW'(nr - CW'(1));
    assign nk_m1 = IW'(nk - CW'(1));
    assign nc_m1 = IW'(nc - CW'(1));

    // whole compute pipeline moves only when the output register can take a result
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign issue    = (state_reg == ST_CALC);

    assign wr_addr   = AW'(ld_hi_reg) * AW'(MAX_DIM) + AW'(ld_lo_reg);
    assign rd_a_addr = AW'(r_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign rd_b_addr = AW'(k_reg) * AW'(MAX_DIM) + AW'(c_reg);

    assign lo_last = ld_b_reg ? (ld_lo_reg == nc_m1) : (ld_lo_reg == nk_m1);
    assign hi_last = ld_b_reg ? (ld_hi_reg == nk_m1) : (ld_hi_reg == nr_m1);

    assign issue_tag.first = (k_reg == '0);
    assign issue_tag.lastk = (k_reg == nk_m1);
    assign issue_tag.fin   = (k_reg == nk_m1) && (r_reg == nr_m1) && (c_reg == nc_m1);
    assign issue_tag.r     = r_reg;
    assign issue_tag.c     = c_reg;

    assign sum = tag2_reg.first ? prod_reg : acc_reg + prod_reg;

    imm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (in_fire && !ld_b_reg),
        .waddr (wr_addr),
        .wdata (element),
        .re    (adv),
        .raddr (rd_a_addr),
        .rdata (a_rdata)
    );

    imm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (in_fire && ld_b_reg),
        .waddr (wr_addr),
        .wdata (element),
        .re    (adv),
        .raddr (rd_b_addr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rows_a_next    = rows_a_reg;
        inner_len_next = inner_len_reg;
        cols_b_next    = cols_b_reg;
        ld_b_next      = ld_b_reg;
        ld_hi_next     = ld_hi_reg;
        ld_lo_next     = ld_lo_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        v1_next        = v1_reg;
        tag1_next      = tag1_reg;
        v2_next        = v2_reg;
        tag2_next      = tag2_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        product_next   = product_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        last_next      = last_reg;

        // load sequencing
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ROWS_A:
                begin
                    rows_a_next = cfg_wdata;
                    ld_b_next   = 1'b0;
                    ld_hi_next  = '0;
                    ld_lo_next  = '0;
                end
                CFG_INNER_LEN:
                begin
                    inner_len_next = cfg_wdata;
                    ld_b_next      = 1'b0;
                    ld_hi_next     = '0;
                    ld_lo_next     = '0;
                end
                CFG_COLS_B:
                begin
                    cols_b_next = cfg_wdata;
                    ld_b_next   = 1'b0;
                    ld_hi_next  = '0;
                    ld_lo_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            if (lo_last)
            begin
                ld_lo_next = '0;
                if (hi_last)
                begin
                    ld_hi_next = '0;
                    if (ld_b_reg)
                    begin
                        ld_b_next  = 1'b0;
                        state_next = ST_CALC;
                        r_next     = '0;
                        c_next     = '0;
                        k_next     = '0;
                    end
                    else
                    begin
                        ld_b_next = 1'b1;
                    end
                end
                else
                begin
                    ld_hi_next = ld_hi_reg + 1'b1;
                end
            end
            else
            begin
                ld_lo_next = ld_lo_reg + 1'b1;
            end
        end

        // multiply-accumulate pipeline: issue, memory read, multiply, accumulate
        if (adv)
        begin
            v1_next   = issue;
            tag1_next = issue_tag;
            v2_next   = v1_reg;
            tag2_next = tag1_reg;
            prod_next = a_rdata * b_rdata;

            if (issue)
            begin
                if (issue_tag.lastk)
                begin
                    k_next = '0;
                    if (c_reg == nc_m1)
                    begin
                        c_next = '0;
                        r_next = r_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
                if (issue_tag.fin)
                begin
                    state_next = ST_LOAD;
                    r_next     = '0;
                    c_next     = '0;
                end
            end

            if (v2_reg)
            begin
                acc_next = sum;
            end

            out_valid_next = v2_reg && tag2_reg.lastk;
            if (v2_reg && tag2_reg.lastk)
            begin
                product_next = sum;
                out_row_next = IDX_OUT_W'(32'(tag2_reg.r));
                out_col_next = IDX_OUT_W'(32'(tag2_reg.c));
                last_next    = tag2_reg.fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            rows_a_reg    <= DIM_RESET;
            inner_len_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
            ld_b_reg      <= 1'b0;
            ld_hi_reg     <= '0;
            ld_lo_reg     <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            tag1_reg      <= '0;
            v2_reg        <= 1'b0;
            tag2_reg      <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            product_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_a_reg    <= rows_a_next;
            inner_len_reg <= inner_len_next;
            cols_b_reg    <= cols_b_next;
            ld_b_reg      <= ld_b_next;
            ld_hi_reg     <= ld_hi_next;
            ld_lo_reg     <= ld_lo_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            v1_reg        <= v1_next;
            tag1_reg      <= tag1_next;
            v2_reg        <= v2_next;
            tag2_reg      <= tag2_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            product_reg   <= product_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;

    // a held result stays valid and freezes the accumulator and the pipeline valid flags
    `CHK_NEXT(a_stall_freeze, out_valid_reg && !out_ready, out_valid_reg && $stable(acc_reg) && $stable(v1_reg) && $stable(v2_reg), "pipeline moved while result held")

    // a new result only comes from the end of a dot product
    `CHK_IMPL(a_result_src, $rose(out_valid_reg), $past(v2_reg && tag2_reg.lastk), "result without finished dot product")

    // the final entry always closes a dot product
    `CHK_IMPL(a_fin_lastk, v2_reg && tag2_reg.fin, tag2_reg.lastk, "final entry tag without last term")

endmodule

@@ hw/rtl/imm_ram.sv @@
// ---------------------------------------------------------------------------
// imm_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
